>>> design/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// Button divert protocol controller: shared definitions
// Operation and phase codes, protocol constants and the payload structs of
// the item and result channels.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  // Longest report length that is counted before the count saturates.
  localparam int REPORT_LEN_MAX_DEF = 63;

  // Retry limit after reset.
  localparam logic [7:0] MAX_RETRIES_RST = 8'd32;

  // Control ids of the two buttons and the id of the feature looked up.
  localparam logic [15:0] CID_BACK    = 16'h0053;
  localparam logic [15:0] CID_FORWARD = 16'h0056;
  localparam logic [15:0] FEATURE_ID  = 16'h1B04;

  // Report framing codes.
  localparam logic [7:0] KIND_SHORT = 8'h10;
  localparam logic [7:0] KIND_LONG  = 8'h11;
  localparam logic [7:0] ERR_MARK   = 8'hFF;
  localparam logic [3:0] SW_ID      = 4'h2;
  localparam logic [3:0] FN_QUERY   = 4'h0;
  localparam logic [3:0] FN_SET     = 4'h3;

  // Button mask bits.
  localparam logic [1:0] BTN_BACK    = 2'b01;
  localparam logic [1:0] BTN_FORWARD = 2'b10;

  typedef enum logic [1:0] {
    OP_CONNECT    = 2'd0,
    OP_DISCONNECT = 2'd1,
    OP_TICK       = 2'd2,
    OP_REPORT     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    SEND_NONE   = 2'd0,
    SEND_QUERY  = 2'd1,
    SEND_DIVERT = 2'd2
  } send_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_NEED   = 3'd1,
    PH_WAITF  = 3'd2,
    PH_READY  = 3'd3,
    PH_WAITS  = 3'd4,
    PH_FAILED = 3'd5
  } phase_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] target_mask;
    logic [1:0] unsupported_mask;
    logic       send_accepted;
    logic [7:0] report_kind;
    logic [7:0] report_byte;
    logic       byte_last;
  } item_t;

  typedef struct packed {
    send_e       send_kind;
    logic [7:0]  send_feature;
    logic [15:0] send_control_id;
    logic        send_enable;
    logic        report_claimed;
    logic        is_connected;
    logic [7:0]  feature_slot;
    logic [1:0]  wanted;
    logic [1:0]  applied;
    logic [1:0]  held;
    logic [1:0]  supported;
    logic [1:0]  failed;
  } result_t;

endpackage

>>> design/bdpc_if.sv
// ----------------------------------------------------------------------------
// Button divert protocol controller: channel interfaces
// Valid/ready channels for the item words going in and the result words
// coming out.
// ----------------------------------------------------------------------------
interface bdpc_item_if;
  import bdpc_pkg::*;

  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bdpc_result_if;
  import bdpc_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/bdpc_core.sv
// ----------------------------------------------------------------------------
// Button divert protocol controller: protocol state and step logic
// Holds the link, divert and report stream state and works out, for one
// item, the next state and the status snapshot in a single pass.
// ----------------------------------------------------------------------------
module bdpc_core #(
  parameter int REPORT_LEN_MAX = bdpc_pkg::REPORT_LEN_MAX_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              step_i,
  input  bdpc_pkg::item_t   item_i,
  output bdpc_pkg::result_t result_o
);
  import bdpc_pkg::*;

  localparam int CNT_W = $clog2(REPORT_LEN_MAX + 1);

  // Registered state.
  logic [7:0]       max_retries_q;
  logic             link_up_q, link_up_d;
  phase_e           phase_q, phase_d;
  logic [7:0]       feature_q, feature_d;
  logic [1:0]       desired_q, desired_d;
  logic [1:0]       last_desired_q, last_desired_d;
  logic [1:0]       applied_q, applied_d;
  logic [1:0]       held_q, held_d;
  logic [1:0]       supported_q, supported_d;
  logic [1:0]       pfail_q, pfail_d;
  logic [1:0]       ext_unsup_q, ext_unsup_d;
  logic [1:0]       pend_btn_q, pend_btn_d;
  logic             pend_on_q, pend_on_d;
  logic [7:0]       retry_q, retry_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       hdr_q [4];
  logic [7:0]       hdr_d [4];
  logic [1:0]       held_acc_q, held_acc_d;
  logic [7:0]       pair_hi_q, pair_hi_d;
  logic             ended_q, ended_d;

  // Error reply for the given feature and function: the marker, the feature
  // index, then the function and software id.
  function automatic logic err_match(logic [7:0] h1, logic [7:0] h2, logic [7:0] h3,
                                     logic [7:0] feat, logic [3:0] fn);
    return (h1 == ERR_MARK) && (h2 == feat) && (h3[7:4] == fn) && (h3[3:0] == SW_ID);
  endfunction

  // Next state and the snapshot for the item in the stage register.
  always_comb begin
    logic [1:0]  fresh;
    logic [1:0]  eff;
    logic [1:0]  diff;
    logic [1:0]  bit_sel;
    logic        en;
    logic [15:0] cid;
    logic        len_ge3;
    logic        len_ge4;
    logic        len_ge5;
    logic        claimed;
    logic        kind_ok;
    logic        engaged;
    result_t     res;

    link_up_d      = link_up_q;
    phase_d        = phase_q;
    feature_d      = feature_q;
    desired_d      = desired_q;
    last_desired_d = last_desired_q;
    applied_d      = applied_q;
    held_d         = held_q;
    supported_d    = supported_q;
    pfail_d        = pfail_q;
    ext_unsup_d    = ext_unsup_q;
    pend_btn_d     = pend_btn_q;
    pend_on_d      = pend_on_q;
    retry_d        = retry_q;
    cnt_d          = cnt_q;
    hdr_d          = hdr_q;
    held_acc_d     = held_acc_q;
    pair_hi_d      = pair_hi_q;
    ended_d        = ended_q;
    fresh          = '0;
    eff            = '0;
    diff           = '0;
    bit_sel        = '0;
    en             = 1'b0;
    cid            = '0;
    len_ge3        = 1'b0;
    len_ge4        = 1'b0;
    len_ge5        = 1'b0;
    claimed        = 1'b0;
    kind_ok        = 1'b0;
    engaged        = 1'b0;
    res            = '0;

    case (item_i.op) inside
      OP_CONNECT, OP_DISCONNECT: begin
        link_up_d      = (item_i.op == OP_CONNECT);
        phase_d        = PH_IDLE;
        feature_d      = '0;
        desired_d      = '0;
        last_desired_d = '0;
        applied_d      = '0;
        held_d         = '0;
        supported_d    = '0;
        pfail_d        = '0;
        ext_unsup_d    = '0;
        pend_btn_d     = '0;
        retry_d        = '0;
        cnt_d          = '0;
        hdr_d          = '{default: '0};
        held_acc_d     = '0;
        pair_hi_d      = '0;
        ended_d        = 1'b0;
        // A disconnect keeps the direction of the last divert request.
        if (item_i.op == OP_CONNECT) begin
          pend_on_d = 1'b0;
        end
      end

      OP_TICK: begin
        if (link_up_q) begin
          // A change of the wanted mask re-arms buttons that were just added.
          if (item_i.target_mask != last_desired_q) begin
            fresh          = item_i.target_mask & ~last_desired_q;
            pfail_d        = pfail_q & ~fresh & item_i.target_mask;
            last_desired_d = item_i.target_mask;
            desired_d      = item_i.target_mask;
            if ((fresh != '0) && (feature_q == '0) && (phase_q == PH_FAILED)) begin
              phase_d = PH_NEED;
            end
          end
          ext_unsup_d = item_i.unsupported_mask;

          if ((phase_d == PH_WAITF) || (phase_d == PH_WAITS)) begin
            // A reply is outstanding: nothing is sent.
          end else if (feature_q == '0) begin
            // Feature index still unknown: query it while anything is wanted.
            if (desired_d == '0) begin
              phase_d = PH_IDLE;
            end else if (phase_d != PH_FAILED) begin
              phase_d             = PH_NEED;
              res.send_kind       = SEND_QUERY;
              res.send_control_id = FEATURE_ID;
              if (item_i.send_accepted) begin
                phase_d = PH_WAITF;
                retry_d = '0;
              end else begin
                retry_d = retry_q + 8'd1;
                if (retry_d >= max_retries_q) begin
                  pfail_d = pfail_d | desired_d;
                  phase_d = PH_FAILED;
                  retry_d = '0;
                end
              end
            end
          end else begin
            // Divert or release the lowest button that is out of step.
            phase_d = PH_READY;
            eff     = desired_d & ~pfail_d;
            diff    = applied_q ^ eff;
            if (diff != '0) begin
              bit_sel             = diff[0] ? BTN_BACK : BTN_FORWARD;
              en                  = (eff & bit_sel) != '0;
              pend_btn_d          = bit_sel;
              res.send_kind       = SEND_DIVERT;
              res.send_feature    = feature_q;
              res.send_control_id = (bit_sel == BTN_BACK) ? CID_BACK : CID_FORWARD;
              res.send_enable     = en;
              if (item_i.send_accepted) begin
                pend_on_d = en;
                phase_d   = PH_WAITS;
                retry_d   = '0;
              end else begin
                retry_d = retry_q + 8'd1;
                if (retry_d >= max_retries_q) begin
                  if (en) begin
                    pfail_d = pfail_d | bit_sel;
                  end
                  retry_d = '0;
                end
              end
            end
          end
        end
      end

      default: begin
        // Report byte: header capture and held-list parsing until saturation.
        if (cnt_q < CNT_W'(REPORT_LEN_MAX)) begin
          for (int k = 0; k < 4; k++) begin
            if (cnt_q == CNT_W'(k)) begin
              hdr_d[k] = item_i.report_byte;
            end
          end
          if (cnt_q >= CNT_W'(3)) begin
            if (cnt_q[0]) begin
              pair_hi_d = item_i.report_byte;
            end else if (!ended_q) begin
              cid = {pair_hi_q, item_i.report_byte};
              if (cid == '0) begin
                ended_d = 1'b1;
              end else if (cid == CID_BACK) begin
                held_acc_d = held_acc_q | BTN_BACK;
              end else if (cid == CID_FORWARD) begin
                held_acc_d = held_acc_q | BTN_FORWARD;
              end
            end
          end
          cnt_d = cnt_q + CNT_W'(1);
        end

        // Judge the whole report at its last byte.
        if (item_i.byte_last) begin
          len_ge3 = cnt_d >= CNT_W'(3);
          len_ge4 = cnt_d >= CNT_W'(4);
          len_ge5 = cnt_d >= CNT_W'(5);
          kind_ok = (item_i.report_kind == KIND_SHORT) || (item_i.report_kind == KIND_LONG);
          engaged = (desired_q != '0) || (applied_q != '0) || (phase_q == PH_WAITF) ||
                    (phase_q == PH_WAITS) || (feature_q != '0);

          if (link_up_q && kind_ok && engaged) begin
            claimed = 1'b1;
            if (!len_ge3) begin
              // Too short to carry a header: taken and ignored.
            end else if ((phase_q == PH_WAITF) && len_ge5 &&
                         err_match(hdr_d[1], hdr_d[2], hdr_d[3], 8'h00, FN_QUERY)) begin
              pfail_d = pfail_q | desired_q;
              phase_d = PH_FAILED;
            end else if ((phase_q == PH_WAITS) && len_ge5 &&
                         err_match(hdr_d[1], hdr_d[2], hdr_d[3], feature_q, FN_SET)) begin
              if (pend_on_q) begin
                pfail_d = pfail_q | pend_btn_q;
              end else begin
                applied_d = applied_q & ~pend_btn_q;
              end
              held_d     = held_q & ~pend_btn_q;
              phase_d    = PH_READY;
              pend_btn_d = '0;
            end else if ((phase_q == PH_WAITF) && (hdr_d[1] == 8'h00) &&
                         (hdr_d[2][7:4] == FN_QUERY) && (hdr_d[2][3:0] == SW_ID) &&
                         len_ge4) begin
              feature_d = hdr_d[3];
              if (hdr_d[3] == '0) begin
                pfail_d = pfail_q | desired_q;
                phase_d = PH_FAILED;
              end else begin
                phase_d = PH_READY;
              end
            end else if ((phase_q == PH_WAITS) && (hdr_d[1] == feature_q) &&
                         (hdr_d[2][7:4] == FN_SET) && (hdr_d[2][3:0] == SW_ID)) begin
              if (pend_on_q) begin
                applied_d   = applied_q | pend_btn_q;
                supported_d = supported_q | pend_btn_q;
                pfail_d     = pfail_q & ~pend_btn_q;
              end else begin
                applied_d = applied_q & ~pend_btn_q;
                held_d    = held_q & ~pend_btn_q;
              end
              pend_btn_d = '0;
              phase_d    = PH_READY;
            end else if ((feature_q != '0) && (hdr_d[1] == feature_q) &&
                         (hdr_d[2][7:4] == FN_QUERY)) begin
              held_d = held_acc_d & applied_q;
            end
          end

          // Every last byte closes the stream.
          cnt_d      = '0;
          hdr_d      = '{default: '0};
          held_acc_d = '0;
          pair_hi_d  = '0;
          ended_d    = 1'b0;
        end
      end
    endcase

    res.report_claimed = claimed;
    res.is_connected   = link_up_d;
    res.feature_slot   = feature_d;
    res.wanted         = desired_d;
    res.applied        = applied_d;
    res.held           = held_d;
    res.supported      = supported_d;
    res.failed         = pfail_d | ext_unsup_d;
    result_o           = res;
  end

  // Retry limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_retries_q <= MAX_RETRIES_RST;
    end else if (cfg_we_i) begin
      max_retries_q <= cfg_data_i;
    end
  end

  // State update, once for each item that leaves the stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_up_q      <= 1'b0;
      phase_q        <= PH_IDLE;
      feature_q      <= '0;
      desired_q      <= '0;
      last_desired_q <= '0;
      applied_q      <= '0;
      held_q         <= '0;
      supported_q    <= '0;
      pfail_q        <= '0;
      ext_unsup_q    <= '0;
      pend_btn_q     <= '0;
      pend_on_q      <= 1'b0;
      retry_q        <= '0;
      cnt_q          <= '0;
      hdr_q          <= '{default: '0};
      held_acc_q     <= '0;
      pair_hi_q      <= '0;
      ended_q        <= 1'b0;
    end else if (step_i) begin
      link_up_q      <= link_up_d;
      phase_q        <= phase_d;
      feature_q      <= feature_d;
      desired_q      <= desired_d;
      last_desired_q <= last_desired_d;
      applied_q      <= applied_d;
      held_q         <= held_d;
      supported_q    <= supported_d;
      pfail_q        <= pfail_d;
      ext_unsup_q    <= ext_unsup_d;
      pend_btn_q     <= pend_btn_d;
      pend_on_q      <= pend_on_d;
      retry_q        <= retry_d;
      cnt_q          <= cnt_d;
      hdr_q          <= hdr_d;
      held_acc_q     <= held_acc_d;
      pair_hi_q      <= pair_hi_d;
      ended_q        <= ended_d;
    end
  end

  // With the link down the controller rests in the idle phase.
  a_down_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !link_up_q |-> (phase_q == PH_IDLE))
    else $error("phase left idle while the link is down");

  // Ready and waiting for a divert reply both need a known feature index.
  a_feature_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == PH_READY) || (phase_q == PH_WAITS)) |-> (feature_q != '0))
    else $error("divert phase without a feature index");

  // Held buttons are diverted, and diverted buttons have been confirmed.
  a_held_applied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((held_q & ~applied_q) == '0) && ((applied_q & ~supported_q) == '0))
    else $error("held, applied and supported masks out of order");

  // The length count stops at the saturation point.
  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(REPORT_LEN_MAX))
    else $error("report length count passed saturation");

endmodule

>>> design/button_divert_protocol_controller_top.sv
// ----------------------------------------------------------------------------
// Button divert protocol controller: top level
// Takes connect, disconnect, tick and report-byte words, drives the feature
// query and button divert commands and returns one status word per item.
//
//   Channel    Dir  Handshake       Carries
//   item_i     in   valid/ready     op, masks, send_accepted, report byte
//   result_o   out  valid/ready     command fields and status snapshot
//   cfg_*_i    in   write enable    max_retries
//
// One item per cycle is sustained while the result channel is not stalled. An
// accepted item is held in the stage register, where the step logic updates
// the state and fills the result register when the stage moves on; the result
// is offered from the result register until it is taken.
// Reset clears all state and sets the retry limit to 32. A stalled result
// register holds the stage, and items are still taken while the stage is
// free or moving on in the same cycle.
// ----------------------------------------------------------------------------
module button_divert_protocol_controller_top #(
  parameter int REPORT_LEN_MAX = bdpc_pkg::REPORT_LEN_MAX_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bdpc_item_if.sink            item_i,
  bdpc_result_if.source        result_o,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_data_i
);
  import bdpc_pkg::*;

  logic    stage_v_q, stage_v_d;
  item_t   stage_q;
  logic    out_v_q, out_v_d;
  result_t out_q;
  result_t step_res;
  logic    advance;
  logic    accept;

  // The stage moves on when the result register is free or being emptied.
  assign advance      = stage_v_q && (!out_v_q || result_o.ready);
  assign item_i.ready = !stage_v_q || advance;
  assign accept       = item_i.valid && item_i.ready;

  assign stage_v_d = accept ? 1'b1 : (advance ? 1'b0 : stage_v_q);
  assign out_v_d   = advance ? 1'b1 : (result_o.ready ? 1'b0 : out_v_q);

  bdpc_core #(
    .REPORT_LEN_MAX (REPORT_LEN_MAX)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (advance),
    .item_i     (stage_q),
    .result_o   (step_res)
  );

  // Valid flags of the stage and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      stage_v_q <= stage_v_d;
      out_v_q   <= out_v_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= item_i.data;
    end
    if (advance) begin
      out_q <= step_res;
    end
  end

  assign result_o.valid = out_v_q;
  assign result_o.data  = out_q;

  // A full stage that cannot move on must block new items.
  a_stage_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_v_q && out_v_q && !result_o.ready) |-> !item_i.ready)
    else $error("item taken while the stage is blocked");

  // Each step of the stage lands in the result register.
  a_step_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_v_q)
    else $error("stepped item left no result");

  // A result that is not taken stays put.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !result_o.ready) |=> (out_v_q && $stable(out_q)))
    else $error("pending result changed before it was taken");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Button divert protocol controller: self-checking testbench
// Drives connect, disconnect, tick and report-byte words through the item
// channel and checks every status word against a behavioural predictor.
// A short table of directed words comes first, then random traffic shaped
// as well-formed protocol exchanges under several retry limits.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bdpc_pkg::*;

  localparam int         LEN_CAP  = REPORT_LEN_MAX_DEF;
  localparam logic [7:0] DIR_SLOT = 8'h0A;

  // One row of the directed table: the word and, where fixed, its status.
  typedef struct {
    item_t   w;
    bit      fixed;
    result_t exp;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [7:0] cfg_data_i;

  bdpc_item_if   item_if ();
  bdpc_result_if result_if ();

  button_divert_protocol_controller_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_if),
    .result_o   (result_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  // Clock with a 10 ns period.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Mirror of the controller state.
  logic       m_link;
  phase_e     m_phase;
  logic [7:0] m_slot;
  logic [1:0] m_want, m_last_want, m_applied, m_held, m_supp, m_pfail, m_unsup;
  logic [1:0] m_pend_btn;
  logic       m_pend_on;
  logic [7:0] m_tries;
  logic [7:0] m_retry_limit;
  int         m_nbytes;
  logic [7:0] m_hdr [4];
  logic [1:0] m_held_acc;
  logic [7:0] m_pair_hi;
  logic       m_list_done;

  // Status words still owed by the block, oldest first.
  result_t status_q [$];

  int errors;
  int words_sent;
  int words_checked;
  int queries_seen;
  int diverts_seen;
  int claims_seen;
  int src_gap_pct;
  int stall_pct;
  logic [1:0] aim;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Forget the partly received report.
  function automatic void clear_frame();
    m_nbytes    = 0;
    for (int i = 0; i < 4; i++) m_hdr[i] = 8'h00;
    m_held_acc  = 2'b00;
    m_pair_hi   = 8'h00;
    m_list_done = 1'b0;
  endfunction

  // Drop everything learnt about the device; the pending direction survives.
  function automatic void clear_session(logic up);
    m_link      = up;
    m_phase     = PH_IDLE;
    m_slot      = 8'h00;
    m_want      = 2'b00;
    m_last_want = 2'b00;
    m_applied   = 2'b00;
    m_held      = 2'b00;
    m_supp      = 2'b00;
    m_pfail     = 2'b00;
    m_unsup     = 2'b00;
    m_pend_btn  = 2'b00;
    m_tries     = 8'h00;
    clear_frame();
  endfunction

  // An error reply naming the given feature index and function.
  function automatic logic err_frame_hit(int len, logic [7:0] feat, logic [3:0] fn);
    return len >= 5 && m_hdr[1] == ERR_MARK && m_hdr[2] == feat &&
           m_hdr[3][7:4] == fn && m_hdr[3][3:0] == SW_ID;
  endfunction

  // A tick: take the masks in and perhaps issue one command.
  function automatic void tick_update(input item_t w, inout result_t r);
    logic [1:0] fresh;
    logic [1:0] eff;
    logic [1:0] diff;
    logic [1:0] btn;
    logic       en;
    if (!m_link) return;
    if (w.target_mask != m_last_want) begin
      fresh       = w.target_mask & ~m_last_want;
      m_pfail     = m_pfail & ~fresh & w.target_mask;
      m_last_want = w.target_mask;
      m_want      = w.target_mask;
      if (fresh != 2'b00 && m_slot == 8'h00 && m_phase == PH_FAILED) m_phase = PH_NEED;
    end
    m_unsup = w.unsupported_mask;
    if (m_phase == PH_WAITF || m_phase == PH_WAITS) return;

    // Feature index still unknown: query it.
    if (m_slot == 8'h00) begin
      if (m_want == 2'b00) begin
        m_phase = PH_IDLE;
        return;
      end
      if (m_phase == PH_FAILED) return;
      m_phase           = PH_NEED;
      r.send_kind       = SEND_QUERY;
      r.send_feature    = 8'h00;
      r.send_control_id = FEATURE_ID;
      r.send_enable     = 1'b0;
      if (w.send_accepted) begin
        m_phase = PH_WAITF;
        m_tries = 8'h00;
      end else begin
        m_tries = m_tries + 8'd1;
        if (m_tries >= m_retry_limit) begin
          m_pfail = m_pfail | m_want;
          m_phase = PH_FAILED;
          m_tries = 8'h00;
        end
      end
      return;
    end

    // Feature known: move one button towards the wanted mask.
    m_phase = PH_READY;
    eff  = m_want & ~m_pfail;
    diff = m_applied ^ eff;
    if (diff == 2'b00) return;
    btn        = diff[0] ? BTN_BACK : BTN_FORWARD;
    en         = |(eff & btn);
    m_pend_btn = btn;
    r.send_kind       = SEND_DIVERT;
    r.send_feature    = m_slot;
    r.send_control_id = (btn == BTN_BACK) ? CID_BACK : CID_FORWARD;
    r.send_enable     = en;
    if (w.send_accepted) begin
      m_pend_on = en;
      m_phase   = PH_WAITS;
      m_tries   = 8'h00;
    end else begin
      m_tries = m_tries + 8'd1;
      if (m_tries >= m_retry_limit) begin
        if (en) m_pfail = m_pfail | btn;
        m_tries = 8'h00;
      end
    end
  endfunction

  // Judge a complete report; returns whether it is protocol traffic.
  function automatic logic frame_verdict(logic [7:0] kind);
    int         len;
    logic [7:0] feat;
    logic [3:0] fn;
    logic [3:0] sw;
    len = m_nbytes;
    if (!m_link) return 1'b0;
    if (kind != KIND_SHORT && kind != KIND_LONG) return 1'b0;
    if (!(m_want != 2'b00 || m_applied != 2'b00 || m_phase == PH_WAITF ||
          m_phase == PH_WAITS || m_slot != 8'h00)) return 1'b0;
    if (len < 3) return 1'b1;

    if (m_phase == PH_WAITF && err_frame_hit(len, 8'h00, FN_QUERY)) begin
      m_pfail = m_pfail | m_want;
      m_phase = PH_FAILED;
      return 1'b1;
    end
    if (m_phase == PH_WAITS && err_frame_hit(len, m_slot, FN_SET)) begin
      if (m_pend_on) m_pfail = m_pfail | m_pend_btn;
      else m_applied = m_applied & ~m_pend_btn;
      m_held     = m_held & ~m_pend_btn;
      m_phase    = PH_READY;
      m_pend_btn = 2'b00;
      return 1'b1;
    end
    feat = m_hdr[1];
    fn   = m_hdr[2][7:4];
    sw   = m_hdr[2][3:0];

    // Reply to the feature query.
    if (m_phase == PH_WAITF && feat == 8'h00 && fn == FN_QUERY && sw == SW_ID &&
        len >= 4) begin
      m_slot = m_hdr[3];
      if (m_slot == 8'h00) begin
        m_pfail = m_pfail | m_want;
        m_phase = PH_FAILED;
      end else begin
        m_phase = PH_READY;
      end
      return 1'b1;
    end
    // Acknowledge of the divert request.
    if (m_phase == PH_WAITS && feat == m_slot && fn == FN_SET && sw == SW_ID) begin
      if (m_pend_on) begin
        m_applied = m_applied | m_pend_btn;
        m_supp    = m_supp | m_pend_btn;
        m_pfail   = m_pfail & ~m_pend_btn;
      end else begin
        m_applied = m_applied & ~m_pend_btn;
        m_held    = m_held & ~m_pend_btn;
      end
      m_pend_btn = 2'b00;
      m_phase    = PH_READY;
      return 1'b1;
    end
    // Held-button list.
    if (m_slot != 8'h00 && feat == m_slot && fn == FN_QUERY) m_held = m_held_acc & m_applied;
    return 1'b1;
  endfunction

  // Take one report byte; pairs from byte 3 on form the held list.
  function automatic void frame_byte(logic [7:0] b);
    int          idx;
    logic [15:0] cid;
    idx = m_nbytes;
    if (idx >= LEN_CAP) return;
    if (idx < 4) m_hdr[idx] = b;
    if (idx >= 3) begin
      if ((idx - 3) % 2 == 0) begin
        m_pair_hi = b;
      end else if (!m_list_done) begin
        cid = {m_pair_hi, b};
        if (cid == 16'h0000) m_list_done = 1'b1;
        else if (cid == CID_BACK) m_held_acc = m_held_acc | BTN_BACK;
        else if (cid == CID_FORWARD) m_held_acc = m_held_acc | BTN_FORWARD;
      end
    end
    m_nbytes = idx + 1;
  endfunction

  // Status word caused by one accepted word.
  function automatic result_t predict_status(item_t w);
    result_t r;
    r = '0;
    case (w.op)
      OP_CONNECT: begin
        clear_session(1'b1);
        m_pend_on = 1'b0;
      end
      OP_DISCONNECT: clear_session(1'b0);
      OP_TICK:       tick_update(w, r);
      default: begin
        frame_byte(w.report_byte);
        if (w.byte_last) begin
          r.report_claimed = frame_verdict(w.report_kind);
          clear_frame();
        end
      end
    endcase
    r.is_connected = m_link;
    r.feature_slot = m_slot;
    r.wanted       = m_want;
    r.applied      = m_applied;
    r.held         = m_held;
    r.supported    = m_supp;
    r.failed       = m_pfail | m_unsup;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Word builders
  // ---------------------------------------------------------------------------

  function automatic item_t tick_word(logic [1:0] d, logic [1:0] u, logic acc);
    item_t w;
    w = '0;
    w.op               = OP_TICK;
    w.target_mask      = d;
    w.unsupported_mask = u;
    w.send_accepted    = acc;
    return w;
  endfunction

  function automatic item_t byte_word(logic [7:0] kind, logic [7:0] b, logic last);
    item_t w;
    w = '0;
    w.op          = OP_REPORT;
    w.report_kind = kind;
    w.report_byte = b;
    w.byte_last   = last;
    return w;
  endfunction

  function automatic item_t link_word(op_e o);
    item_t w;
    w = '0;
    w.op = o;
    return w;
  endfunction

  function automatic result_t snap(send_e k, logic [15:0] cid, logic conn, logic [1:0] want);
    result_t r;
    r = '0;
    r.send_kind       = k;
    r.send_control_id = cid;
    r.is_connected    = conn;
    r.wanted          = want;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Item channel driver
  // ---------------------------------------------------------------------------

  // Offer one word, wait for it to be taken, then log what it should cause.
  task automatic send_word(item_t w, bit fixed = 1'b0, result_t typed = '0);
    result_t r;
    while ($urandom_range(0, 99) < src_gap_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.data  <= w;
    do @(posedge clk_i); while (!item_if.ready);
    words_sent++;
    r = predict_status(w);
    if (r.send_kind == SEND_QUERY) queries_seen++;
    if (r.send_kind == SEND_DIVERT) diverts_seen++;
    if (r.report_claimed) claims_seen++;
    status_q.push_back(fixed ? typed : r);
  endtask

  // Stream a report; only the kind on the final byte matters to the block.
  task automatic send_frame(logic [7:0] frm [$], logic [7:0] kind);
    logic last;
    for (int i = 0; i < frm.size(); i++) begin
      last = (i == frm.size() - 1);
      send_word(byte_word(last ? kind : 8'($urandom), frm[i], last));
    end
  endtask

  // Wait for every owed status word, then for the pipeline to settle.
  task automatic settle();
    item_if.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Change the retry limit while the block is idle.
  task automatic set_retry_limit(logic [7:0] v);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    m_retry_limit = v;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------

  task automatic run_directed();
    dir_row_t rows [22];
    // Quiet link: neither ticks nor reports have any effect.
    rows[0]  = '{tick_word(2'b11, 2'b11, 1'b1), 1'b1, snap(SEND_NONE, 16'h0, 1'b0, 2'b00)};
    rows[1]  = '{byte_word(KIND_LONG, 8'hFF, 1'b1), 1'b1, snap(SEND_NONE, 16'h0, 1'b0, 2'b00)};
    rows[2]  = '{link_word(OP_CONNECT), 1'b1, snap(SEND_NONE, 16'h0, 1'b1, 2'b00)};
    // Feature query refused once, then taken.
    rows[3]  = '{tick_word(2'b11, 2'b00, 1'b0), 1'b1, snap(SEND_QUERY, FEATURE_ID, 1'b1, 2'b11)};
    rows[4]  = '{tick_word(2'b11, 2'b00, 1'b1), 1'b1, snap(SEND_QUERY, FEATURE_ID, 1'b1, 2'b11)};
    // Feature reply; the early bytes carry a kind that is not looked at.
    rows[5]  = '{byte_word(8'h00, 8'h01, 1'b0), 1'b0, '0};
    rows[6]  = '{byte_word(8'hFF, 8'h00, 1'b0), 1'b0, '0};
    rows[7]  = '{byte_word(8'h00, {FN_QUERY, SW_ID}, 1'b0), 1'b0, '0};
    rows[8]  = '{byte_word(KIND_LONG, DIR_SLOT, 1'b1), 1'b0, '0};
    // Divert the back button and acknowledge it.
    rows[9]  = '{tick_word(2'b11, 2'b00, 1'b1), 1'b0, '0};
    rows[10] = '{byte_word(KIND_SHORT, 8'h01, 1'b0), 1'b0, '0};
    rows[11] = '{byte_word(KIND_SHORT, DIR_SLOT, 1'b0), 1'b0, '0};
    rows[12] = '{byte_word(KIND_SHORT, {FN_SET, SW_ID}, 1'b1), 1'b0, '0};
    // Divert the forward button and have it refused with an error reply.
    rows[13] = '{tick_word(2'b11, 2'b00, 1'b1), 1'b0, '0};
    rows[14] = '{byte_word(KIND_LONG, 8'h01, 1'b0), 1'b0, '0};
    rows[15] = '{byte_word(KIND_LONG, ERR_MARK, 1'b0), 1'b0, '0};
    rows[16] = '{byte_word(KIND_LONG, DIR_SLOT, 1'b0), 1'b0, '0};
    rows[17] = '{byte_word(KIND_LONG, {FN_SET, SW_ID}, 1'b0), 1'b0, '0};
    rows[18] = '{byte_word(KIND_LONG, 8'h05, 1'b1), 1'b0, '0};
    // Both buttons marked unsupported from outside, then a foreign report.
    rows[19] = '{tick_word(2'b11, 2'b11, 1'b1), 1'b0, '0};
    rows[20] = '{byte_word(8'h20, 8'h00, 1'b1), 1'b0, '0};
    rows[21] = '{link_word(OP_DISCONNECT), 1'b1, snap(SEND_NONE, 16'h0, 1'b0, 2'b00)};
    foreach (rows[i]) send_word(rows[i].w, rows[i].fixed, rows[i].exp);
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic
  // ---------------------------------------------------------------------------

  task automatic run_random(int n);
    int          stop;
    int          pick;
    int          npairs;
    bit          burst_done;
    logic [7:0]  frm [$];
    logic [7:0]  kind;
    logic [7:0]  slot;
    logic [3:0]  sw;
    logic [15:0] c;
    stop       = words_sent + n;
    burst_done = 1'b0;
    while (words_sent < stop) begin
      pick = $urandom_range(0, 99);
      frm.delete();
      kind = ($urandom_range(0, 9) == 0) ? 8'($urandom) :
             ($urandom_range(0, 1) ? KIND_LONG : KIND_SHORT);
      sw   = ($urandom_range(0, 9) == 0) ? 4'($urandom) : SW_ID;

      if (!m_link ? pick < 70 : pick < 2) begin
        send_word(link_word(OP_CONNECT));
      end else if (pick < 4) begin
        send_word(link_word(OP_DISCONNECT));
      end else if (!burst_done && m_link && words_sent > stop - (2 * n) / 3) begin
        // A dead link: every command refused until the retry limit is hit.
        burst_done = 1'b1;
        if (aim == 2'b00) aim = 2'b11;
        for (int k = 0; k < int'(m_retry_limit) + 2; k++)
          send_word(tick_word(aim, 2'b00, 1'b0));
      end else if (pick < 48) begin
        if ($urandom_range(0, 99) < 15) aim = 2'($urandom);
        send_word(tick_word(aim, ($urandom_range(0, 4) == 0) ? 2'($urandom) : 2'b00,
                            $urandom_range(0, 99) < 75));
      end else if (m_phase == PH_WAITF && pick < 80) begin
        frm.push_back(8'($urandom));
        if (pick < 66) begin
          // Feature reply, now and then reporting index zero or 0xFF.
          slot = ($urandom_range(0, 9) == 0) ? 8'h00 :
                 ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom_range(1, 254));
          frm.push_back(8'h00);
          frm.push_back({FN_QUERY, sw});
          frm.push_back(slot);
        end else begin
          frm.push_back(ERR_MARK);
          frm.push_back(8'h00);
          frm.push_back({FN_QUERY, sw});
          if ($urandom_range(0, 9) != 0) frm.push_back(8'($urandom));
        end
        repeat ($urandom_range(0, 2)) frm.push_back(8'($urandom));
        send_frame(frm, kind);
      end else if (m_phase == PH_WAITS && pick < 85) begin
        frm.push_back(8'($urandom));
        if (pick < 70) begin
          frm.push_back(m_slot);
          frm.push_back({($urandom_range(0, 9) == 0) ? 4'($urandom) : FN_SET, sw});
        end else begin
          frm.push_back(ERR_MARK);
          frm.push_back(m_slot);
          frm.push_back({FN_SET, sw});
          frm.push_back(8'($urandom));
        end
        repeat ($urandom_range(0, 3)) frm.push_back(8'($urandom));
        send_frame(frm, kind);
      end else if (pick < 82) begin
        // Held-button list with a random mix of ids, zero ends included.
        frm.push_back(8'($urandom));
        frm.push_back(($urandom_range(0, 9) != 0 && m_slot != 8'h00) ? m_slot : 8'($urandom));
        frm.push_back({FN_QUERY, ($urandom_range(0, 4) != 0) ? SW_ID : 4'($urandom)});
        npairs = $urandom_range(0, 4);
        for (int k = 0; k < npairs; k++) begin
          case ($urandom_range(0, 4))
            0, 1:    c = CID_BACK;
            2:       c = CID_FORWARD;
            3:       c = 16'h0000;
            default: c = 16'($urandom);
          endcase
          frm.push_back(c[15:8]);
          frm.push_back(c[7:0]);
        end
        if ($urandom_range(0, 4) == 0) frm.push_back(8'($urandom));
        // An occasional report long enough to saturate the length count.
        if ($urandom_range(0, 15) == 0)
          repeat ($urandom_range(55, 75)) frm.push_back(8'($urandom));
        send_frame(frm, kind);
      end else begin
        // Noise: short or long reports of random bytes.
        repeat (($urandom_range(0, 19) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 8))
          frm.push_back(8'($urandom));
        send_frame(frm, kind);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result channel: random stalls and checking
  // ---------------------------------------------------------------------------

  task automatic check_field(string what, logic [15:0] exp, logic [15:0] got);
    if (exp !== got) begin
      errors++;
      $display("%0t ns: %s expected %h, got %h", $time, what, exp, got);
    end
  endtask

  initial begin : status_sink
    result_t got;
    result_t exp;
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
        got = result_if.data;
        if (status_q.size() == 0) begin
          errors++;
          $display("%0t ns: status word %h arrived with none owed", $time, got);
        end else begin
          exp = status_q.pop_front();
          words_checked++;
          check_field("send_kind", 16'(exp.send_kind), 16'(got.send_kind));
          check_field("send_feature", 16'(exp.send_feature), 16'(got.send_feature));
          check_field("send_control_id", exp.send_control_id, got.send_control_id);
          check_field("send_enable", 16'(exp.send_enable), 16'(got.send_enable));
          check_field("report_claimed", 16'(exp.report_claimed), 16'(got.report_claimed));
          check_field("is_connected", 16'(exp.is_connected), 16'(got.is_connected));
          check_field("feature_slot", 16'(exp.feature_slot), 16'(got.feature_slot));
          check_field("wanted", 16'(exp.wanted), 16'(got.wanted));
          check_field("applied", 16'(exp.applied), 16'(got.applied));
          check_field("held", 16'(exp.held), 16'(got.held));
          check_field("supported", 16'(exp.supported), 16'(got.supported));
          check_field("failed", 16'(exp.failed), 16'(got.failed));
        end
      end
      result_if.ready <= rst_ni && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Run sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    logic [7:0] last_limit;
    item_if.valid = 1'b0;
    item_if.data  = '0;
    cfg_we_i      = 1'b0;
    cfg_data_i    = 8'h00;
    rst_ni        = 1'b0;
    errors        = 0;
    words_sent    = 0;
    words_checked = 0;
    queries_seen  = 0;
    diverts_seen  = 0;
    claims_seen   = 0;
    src_gap_pct   = 25;
    stall_pct     = 25;
    aim           = 2'b11;
    m_retry_limit = MAX_RETRIES_RST;
    m_pend_on     = 1'b0;
    clear_session(1'b0);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Retry limit as left by reset.
    run_directed();
    run_random(500);

    // A limit of one, with both sides streaming without a gap.
    set_retry_limit(8'd1);
    src_gap_pct = 0;
    stall_pct   = 0;
    run_random(350);
    src_gap_pct = 25;
    stall_pct   = 25;

    // Largest limit, then zero, then one picked at random.
    set_retry_limit(8'd255);
    run_random(450);
    set_retry_limit(8'd0);
    run_random(250);
    last_limit = 8'($urandom_range(2, 254));
    set_retry_limit(last_limit);
    run_random(350);

    settle();
    $display("Run covered %0d words and %0d checked status words under retry limits",
             words_sent, words_checked);
    $display("32, 1, 255, 0 and %0d: %0d queries, %0d diverts, %0d claimed reports.",
             last_limit, queries_seen, diverts_seen, claims_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #5ms;
    $display("Timed out with %0d status words still owed.", status_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
